/* hdl/comd_pkg.sv */
// Shared constants, codes and command/status types of the center-of-mass gravity block.
package comd_pkg;

  // Set size and derived widths
  localparam int MAX_BODIES = 256;
  localparam int CNT_W      = $clog2(MAX_BODIES + 1);
  localparam int MASS_W     = 16 + $clog2(MAX_BODIES);
  localparam int POS_W      = 32;
  localparam int SUM_W      = 64;
  localparam int G_W        = 32;
  localparam int GM_W       = G_W + MASS_W;
  localparam int NUM_W      = GM_W + 32;
  localparam int MAG_W      = NUM_W;
  localparam int DABS_W     = 33;
  localparam int P_W        = MAG_W + DABS_W;
  localparam int DIV_N      = P_W;
  localparam int DEN_W      = 68;
  localparam int DIV_CNT_W  = $clog2(DIV_N);
  localparam int MUL_CNT_W  = $clog2(DABS_W);
  localparam int S_W        = 66;
  localparam int SQ_STEPS   = 34;
  localparam int SQ_SRC_W   = 2 * SQ_STEPS;
  localparam int SQ_REM_W   = SQ_STEPS + 3;
  localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
  localparam int MAG_BIG_SH = 94;

  typedef enum logic [1:0] {
    FAULT_OK        = 2'd0,
    FAULT_NO_MASS   = 2'd1,
    FAULT_NO_TARGET = 2'd2,
    FAULT_ZERO_DIST = 2'd3
  } fault_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_DIV_CX,
    OP_DIV_CY,
    OP_DIFF,
    OP_SQ_X,
    OP_SQ_Y,
    OP_SQ_SUM,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_MAG,
    OP_MUL_X,
    OP_DIV_X,
    OP_MUL_Y,
    OP_DIV_Y,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    fault_t fault;
  } dp_cmd_t;

  typedef struct packed {
    logic target_seen;
    logic mass_zero;
    logic s_zero;
    logic div_done;
    logic mul_done;
  } dp_stat_t;

endpackage

/* hdl/comd_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module comd_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [comd_pkg::DIV_N-1:0]  num,
  input  logic [comd_pkg::DEN_W-1:0]  den,
  output logic [comd_pkg::DIV_N-1:0]  quo,
  output logic                        done
);

  logic [comd_pkg::DEN_W-1:0]     rem_r;
  logic [comd_pkg::DIV_N-1:0]     quo_r;
  logic [comd_pkg::DEN_W-1:0]     den_r;
  logic [comd_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [comd_pkg::DEN_W:0]       shifted;
  logic [comd_pkg::DEN_W:0]       diff;
  logic                           ge;
  logic                           last;

  // Shift one dividend bit into the remainder and trial-subtract
  assign shifted = {rem_r, quo_r[comd_pkg::DIV_N-1]};
  assign diff    = shifted - {1'b0, den_r};
  assign ge      = shifted >= {1'b0, den_r};
  assign last    = cnt_r == comd_pkg::DIV_CNT_W'(comd_pkg::DIV_N - 1);

  // Control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath: load operands, then advance one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= ge ? diff[comd_pkg::DEN_W-1:0] : shifted[comd_pkg::DEN_W-1:0];
      quo_r <= {quo_r[comd_pkg::DIV_N-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

/* hdl/comd_mul.sv */
// Shift-add serial multiplier, one multiplier bit per cycle.
module comd_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [comd_pkg::MAG_W-1:0]  a,
  input  logic [comd_pkg::DABS_W-1:0] b,
  output logic [comd_pkg::P_W-1:0]    prod,
  output logic                        done
);

  logic [comd_pkg::P_W-1:0]       a_r;
  logic [comd_pkg::DABS_W-1:0]    b_r;
  logic [comd_pkg::P_W-1:0]       p_r;
  logic [comd_pkg::MUL_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic                           last;

  assign last = cnt_r == comd_pkg::MUL_CNT_W'(comd_pkg::DABS_W - 1);

  // Control: busy flag, step count, done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && last;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (last) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Add the shifted multiplicand for each set multiplier bit
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= comd_pkg::P_W'(a);
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= p_r + (b_r[0] ? a_r : '0);
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign prod = p_r;
  assign done = done_r;

endmodule

/* hdl/comd_dp.sv */
// Datapath: accumulators, offset, square root steps, serial units and result registers.
module comd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [31:0]                       cfg_wr_data,
  input  logic signed [31:0]                in_pos_x,
  input  logic signed [31:0]                in_pos_y,
  input  logic [15:0]                       in_body_mass,
  input  logic                              in_is_target,
  input  comd_pkg::dp_cmd_t                 cmd,
  output comd_pkg::dp_stat_t                stat,
  output logic signed [31:0]                out_accel_x,
  output logic signed [31:0]                out_accel_y,
  output logic [1:0]                        out_fault
);

  logic [comd_pkg::G_W-1:0]        g_r;
  logic signed [comd_pkg::SUM_W-1:0] wsx_r, wsy_r;
  logic [comd_pkg::MASS_W-1:0]     mass_r;
  logic [31:0]                     tx_r, ty_r;
  logic                            tseen_r;
  logic [comd_pkg::CNT_W-1:0]      cnt_r;
  logic [32:0]                     cx_r;
  logic [33:0]                     dx_r, dy_r;
  logic [comd_pkg::S_W-1:0]        s_r;
  logic [comd_pkg::SQ_SRC_W-1:0]   sq_src_r;
  logic [comd_pkg::SQ_REM_W-1:0]   sq_rem_r;
  logic [comd_pkg::SQ_STEPS-1:0]   root_r;
  logic [comd_pkg::GM_W-1:0]       gm_r;
  logic [comd_pkg::MAG_W-1:0]      mag_r;
  logic [31:0]                     ox_r;
  logic [31:0]                     out_x_r, out_y_r;
  logic [1:0]                      out_fault_r;

  logic signed [48:0]              pxm, pym;
  logic [63:0]                     wsx_abs, wsy_abs;
  logic [32:0]                     qs_x, qs_y;
  logic [33:0]                     dx_mag, dy_mag;
  logic [comd_pkg::DABS_W-1:0]     ax, ay;
  logic                            negx, negy;
  logic                            mag_big;
  logic [comd_pkg::SQ_REM_W-1:0]   rem2, trial;
  logic                            sq_ge;
  logic                            div_start, mul_start;
  logic [comd_pkg::DIV_N-1:0]      div_num, div_q;
  logic [comd_pkg::DEN_W-1:0]      div_den;
  logic                            div_done, mul_done;
  logic [comd_pkg::MAG_W-1:0]      mul_a;
  logic [comd_pkg::DABS_W-1:0]     mul_b;
  logic [comd_pkg::P_W-1:0]        mul_p;
  logic                            fault_ok;

  // Saturated component with the sign opposite to the offset
  function automatic logic [31:0] comp(logic [comd_pkg::DIV_N-1:0] q, logic big,
                                       logic zero, logic neg);
    logic [31:0] lim;
    logic [31:0] c;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (zero) begin
      c = '0;
    end else if (big || (q > comd_pkg::DIV_N'(lim))) begin
      c = lim;
    end else begin
      c = q[31:0];
    end
    return neg ? (32'd0 - c) : c;
  endfunction

  // Mass-weighted position of the incoming body
  assign pxm = in_pos_x * $signed({1'b0, in_body_mass});
  assign pym = in_pos_y * $signed({1'b0, in_body_mass});

  // Magnitudes of the sums and signed quotients (truncated toward zero)
  assign wsx_abs = wsx_r[63] ? (64'd0 - wsx_r) : wsx_r;
  assign wsy_abs = wsy_r[63] ? (64'd0 - wsy_r) : wsy_r;
  assign qs_x    = wsx_r[63] ? (33'd0 - div_q[32:0]) : div_q[32:0];
  assign qs_y    = wsy_r[63] ? (33'd0 - div_q[32:0]) : div_q[32:0];

  // Offset magnitudes and direction
  assign dx_mag  = dx_r[33] ? (34'd0 - dx_r) : dx_r;
  assign dy_mag  = dy_r[33] ? (34'd0 - dy_r) : dy_r;
  assign ax      = dx_mag[comd_pkg::DABS_W-1:0];
  assign ay      = dy_mag[comd_pkg::DABS_W-1:0];
  assign negx    = !dx_r[33] && (dx_r != '0);
  assign negy    = !dy_r[33] && (dy_r != '0);
  assign mag_big = (mag_r >> comd_pkg::MAG_BIG_SH) != '0;

  // One digit step of the square root
  assign rem2  = {sq_rem_r[comd_pkg::SQ_REM_W-3:0],
                  sq_src_r[comd_pkg::SQ_SRC_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign sq_ge = rem2 >= trial;

  assign fault_ok = cmd.fault == comd_pkg::FAULT_OK;

  // Select operands for the shared serial units
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (cmd.op)
      comd_pkg::OP_DIV_CX: begin
        div_start = 1'b1;
        div_num   = comd_pkg::DIV_N'(wsx_abs);
        div_den   = comd_pkg::DEN_W'(mass_r);
      end
      comd_pkg::OP_DIV_CY: begin
        div_start = 1'b1;
        div_num   = comd_pkg::DIV_N'(wsy_abs);
        div_den   = comd_pkg::DEN_W'(mass_r);
      end
      comd_pkg::OP_DIV_MAG: begin
        div_start = 1'b1;
        div_num   = comd_pkg::DIV_N'({gm_r, 32'd0});
        div_den   = comd_pkg::DEN_W'(s_r);
      end
      comd_pkg::OP_DIV_X, comd_pkg::OP_DIV_Y: begin
        div_start = 1'b1;
        div_num   = mul_p;
        div_den   = comd_pkg::DEN_W'(root_r);
      end
      comd_pkg::OP_SQ_X: begin
        mul_start = 1'b1;
        mul_a     = comd_pkg::MAG_W'(ax);
        mul_b     = ax;
      end
      comd_pkg::OP_SQ_Y: begin
        mul_start = 1'b1;
        mul_a     = comd_pkg::MAG_W'(ay);
        mul_b     = ay;
      end
      comd_pkg::OP_MUL_X: begin
        mul_start = 1'b1;
        mul_a     = div_q[comd_pkg::MAG_W-1:0];
        mul_b     = ax;
      end
      comd_pkg::OP_MUL_Y: begin
        mul_start = 1'b1;
        mul_a     = mag_r;
        mul_b     = ay;
      end
      default: begin
      end
    endcase
  end

  comd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_q),
    .done  (div_done)
  );

  comd_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_p),
    .done  (mul_done)
  );

  // Hold the gravitational constant
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_r <= comd_pkg::G_W'(65536);
    end else if (cfg_wr_en) begin
      g_r <= cfg_wr_data;
    end
  end

  // Accumulate bodies of the set; clear when the result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsx_r   <= '0;
      wsy_r   <= '0;
      mass_r  <= '0;
      tx_r    <= '0;
      ty_r    <= '0;
      tseen_r <= 1'b0;
      cnt_r   <= '0;
    end else if (cmd.op == comd_pkg::OP_FIN) begin
      wsx_r   <= '0;
      wsy_r   <= '0;
      mass_r  <= '0;
      tx_r    <= '0;
      ty_r    <= '0;
      tseen_r <= 1'b0;
      cnt_r   <= '0;
    end else if ((cmd.op == comd_pkg::OP_ACC) &&
                 (cnt_r < comd_pkg::CNT_W'(comd_pkg::MAX_BODIES))) begin
      cnt_r <= cnt_r + 1'b1;
      if (in_is_target) begin
        if (!tseen_r) begin
          tseen_r <= 1'b1;
          tx_r    <= in_pos_x;
          ty_r    <= in_pos_y;
        end
      end else begin
        wsx_r  <= wsx_r + comd_pkg::SUM_W'(pxm);
        wsy_r  <= wsy_r + comd_pkg::SUM_W'(pym);
        mass_r <= mass_r + comd_pkg::MASS_W'(in_body_mass);
      end
    end
  end

  // Final computation registers, stepped by the controller
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      comd_pkg::OP_DIV_CY: begin
        cx_r <= qs_x;
      end
      comd_pkg::OP_DIFF: begin
        dx_r <= {{2{tx_r[31]}}, tx_r} - {cx_r[32], cx_r};
        dy_r <= {{2{ty_r[31]}}, ty_r} - {qs_y[32], qs_y};
      end
      comd_pkg::OP_SQ_Y: begin
        s_r <= mul_p[comd_pkg::S_W-1:0];
      end
      comd_pkg::OP_SQ_SUM: begin
        s_r <= s_r + mul_p[comd_pkg::S_W-1:0];
      end
      comd_pkg::OP_SQRT_INIT: begin
        sq_src_r <= comd_pkg::SQ_SRC_W'(s_r);
        sq_rem_r <= '0;
        root_r   <= '0;
        gm_r     <= comd_pkg::GM_W'(g_r) * comd_pkg::GM_W'(mass_r);
      end
      comd_pkg::OP_SQRT_STEP: begin
        sq_src_r <= sq_src_r << 2;
        sq_rem_r <= sq_ge ? (rem2 - trial) : rem2;
        root_r   <= {root_r[comd_pkg::SQ_STEPS-2:0], sq_ge};
      end
      comd_pkg::OP_MUL_X: begin
        mag_r <= div_q[comd_pkg::MAG_W-1:0];
      end
      comd_pkg::OP_MUL_Y: begin
        ox_r <= comp(div_q, mag_big, ax == '0, negx);
      end
      default: begin
      end
    endcase
  end

  // Load the result registers
  always_ff @(posedge clk) begin
    if (cmd.op == comd_pkg::OP_FIN) begin
      out_x_r     <= fault_ok ? ox_r : '0;
      out_y_r     <= fault_ok ? comp(div_q, mag_big, ay == '0, negy) : '0;
      out_fault_r <= cmd.fault;
    end
  end

  assign stat.target_seen = tseen_r;
  assign stat.mass_zero   = mass_r == '0;
  assign stat.s_zero      = s_r == '0;
  assign stat.div_done    = div_done;
  assign stat.mul_done    = mul_done;

  assign out_accel_x = out_x_r;
  assign out_accel_y = out_y_r;
  assign out_fault   = out_fault_r;

endmodule

/* hdl/comd_ctrl.sv */
// Controller: accepts bodies, sequences the final computation, owns the result handshake.
module comd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_body,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  comd_pkg::dp_stat_t stat,
  output comd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_ACC   = 16'b0000_0000_0000_0001,
    S_CHECK = 16'b0000_0000_0000_0010,
    S_WCX   = 16'b0000_0000_0000_0100,
    S_WCY   = 16'b0000_0000_0000_1000,
    S_SQX   = 16'b0000_0000_0001_0000,
    S_WSQX  = 16'b0000_0000_0010_0000,
    S_WSQY  = 16'b0000_0000_0100_0000,
    S_ZCHK  = 16'b0000_0000_1000_0000,
    S_SQRT  = 16'b0000_0001_0000_0000,
    S_MAG   = 16'b0000_0010_0000_0000,
    S_WMAG  = 16'b0000_0100_0000_0000,
    S_WMX   = 16'b0000_1000_0000_0000,
    S_WDX   = 16'b0001_0000_0000_0000,
    S_WMY   = 16'b0010_0000_0000_0000,
    S_WDY   = 16'b0100_0000_0000_0000,
    S_FIN   = 16'b1000_0000_0000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  comd_pkg::fault_t             fault_r, fault_nxt;
  logic [comd_pkg::SQ_CNT_W-1:0] sq_cnt_r, sq_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  comd_pkg::dp_op_t             op;
  logic                         in_xfer;

  assign in_stall = state_r != S_ACC;
  assign in_xfer  = in_valid && !in_stall;

  // Next state and datapath command
  always_comb begin
    state_nxt     = state_r;
    fault_nxt     = fault_r;
    sq_cnt_nxt    = sq_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    op            = comd_pkg::OP_NONE;
    unique case (state_r)
      S_ACC: begin
        if (in_xfer) begin
          op = comd_pkg::OP_ACC;
          if (in_last_body) begin
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        priority if (!stat.target_seen) begin
          fault_nxt = comd_pkg::FAULT_NO_TARGET;
          state_nxt = S_FIN;
        end else if (stat.mass_zero) begin
          fault_nxt = comd_pkg::FAULT_NO_MASS;
          state_nxt = S_FIN;
        end else begin
          fault_nxt = comd_pkg::FAULT_OK;
          op        = comd_pkg::OP_DIV_CX;
          state_nxt = S_WCX;
        end
      end
      S_WCX: begin
        if (stat.div_done) begin
          op        = comd_pkg::OP_DIV_CY;
          state_nxt = S_WCY;
        end
      end
      S_WCY: begin
        if (stat.div_done) begin
          op        = comd_pkg::OP_DIFF;
          state_nxt = S_SQX;
        end
      end
      S_SQX: begin
        op        = comd_pkg::OP_SQ_X;
        state_nxt = S_WSQX;
      end
      S_WSQX: begin
        if (stat.mul_done) begin
          op        = comd_pkg::OP_SQ_Y;
          state_nxt = S_WSQY;
        end
      end
      S_WSQY: begin
        if (stat.mul_done) begin
          op        = comd_pkg::OP_SQ_SUM;
          state_nxt = S_ZCHK;
        end
      end
      S_ZCHK: begin
        if (stat.s_zero) begin
          fault_nxt = comd_pkg::FAULT_ZERO_DIST;
          state_nxt = S_FIN;
        end else begin
          op         = comd_pkg::OP_SQRT_INIT;
          sq_cnt_nxt = '0;
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        op         = comd_pkg::OP_SQRT_STEP;
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        if (sq_cnt_r == comd_pkg::SQ_CNT_W'(comd_pkg::SQ_STEPS - 1)) begin
          state_nxt = S_MAG;
        end
      end
      S_MAG: begin
        op        = comd_pkg::OP_DIV_MAG;
        state_nxt = S_WMAG;
      end
      S_WMAG: begin
        if (stat.div_done) begin
          op        = comd_pkg::OP_MUL_X;
          state_nxt = S_WMX;
        end
      end
      S_WMX: begin
        if (stat.mul_done) begin
          op        = comd_pkg::OP_DIV_X;
          state_nxt = S_WDX;
        end
      end
      S_WDX: begin
        if (stat.div_done) begin
          op        = comd_pkg::OP_MUL_Y;
          state_nxt = S_WMY;
        end
      end
      S_WMY: begin
        if (stat.mul_done) begin
          op        = comd_pkg::OP_DIV_Y;
          state_nxt = S_WDY;
        end
      end
      S_WDY: begin
        if (stat.div_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // Load the result once the output register is free
        if (!out_valid_r || !out_stall) begin
          op            = comd_pkg::OP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      fault_r     <= comd_pkg::FAULT_OK;
      sq_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fault_r     <= fault_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign cmd.op    = op;
  assign cmd.fault = fault_nxt;
  assign out_valid = out_valid_r;

endmodule

/* hdl/center_of_mass_gravity_accel.sv */
// Top level of the center-of-mass inverse-square gravity block.
//
// Bodies of one set enter on the in_ channel (valid/stall), one transfer per
// cycle while the block accumulates: mass-weighted positions and total mass of
// every non-target body among the first 256 of the set, and the position of
// the first flagged target. The body with in_last_body high ends the set. The
// block then stalls its input and computes the center of mass, the offset, the
// square root of its squared length and the acceleration on one bit-serial
// divider and one serial multiplier. A full result takes five quotients and
// four products before it reaches the output register; a set without target
// or without other mass skips this computation, and a zero-distance set stops
// after the squared distance.
// The result (out_accel_x, out_accel_y, out_fault) sits in an output register
// with out_valid; while out_stall is high it holds, and the input channel is
// open again for the next set. A following set waits at its end until the
// held result has been transferred.
// cfg_wr_en/cfg_wr_data write the gravitational constant (Q16.16).
// Synchronous reset clears the accumulators, drops out_valid and sets the
// constant to 1.0.
module center_of_mass_gravity_accel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic [15:0]        in_body_mass,
  input  logic               in_is_target,
  input  logic               in_last_body,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_accel_x,
  output logic signed [31:0] out_accel_y,
  output logic [1:0]         out_fault
);

  comd_pkg::dp_cmd_t  cmd;
  comd_pkg::dp_stat_t stat;

  comd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_body (in_last_body),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .stat         (stat),
    .cmd          (cmd)
  );

  comd_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_body_mass (in_body_mass),
    .in_is_target (in_is_target),
    .cmd          (cmd),
    .stat         (stat),
    .out_accel_x  (out_accel_x),
    .out_accel_y  (out_accel_y),
    .out_fault    (out_fault)
  );

  // The set closes on its last body: no further transfer until the result is loaded
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_body) |=> in_stall)
    else $error("input open right after the last body of a set");

  // A faulted result carries zero acceleration
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_fault != comd_pkg::FAULT_OK)) |->
      ((out_accel_x == 32'sd0) && (out_accel_y == 32'sd0)))
    else $error("faulted result with nonzero acceleration");

  // Loading a result raises out_valid and reopens the input channel
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == comd_pkg::OP_FIN) |=> (out_valid && !in_stall))
    else $error("result load did not raise out_valid");

endmodule
